FILE: sv/gpnms_pkg.sv
// Shared types, constants and the arctangent table for the non-maximum suppression block.
package gpnms_pkg;

  localparam int PixW = 15;
  localparam int MagW = 7;
  localparam int DirW = 8;

  localparam logic [2:0]  REG_PADDED_WIDTH   = 3'd0;
  localparam logic [11:0] PADDED_WIDTH_RESET = 12'd2048;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  typedef struct packed {
    logic [PixW-1:0] upper;
    logic [PixW-1:0] lower;
    logic [PixW-1:0] fresh;
    logic            emit;
    logic            last;
  } gpnms_col_t;

  localparam logic [6:0] QUAD_FLOOR [9][9] = '{
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd64, 7'd32, 7'd18, 7'd13, 7'd9,  7'd8,  7'd6,  7'd5,  7'd5},
    '{7'd64, 7'd45, 7'd32, 7'd23, 7'd18, 7'd15, 7'd13, 7'd11, 7'd9},
    '{7'd64, 7'd50, 7'd40, 7'd32, 7'd26, 7'd22, 7'd18, 7'd16, 7'd14},
    '{7'd64, 7'd54, 7'd45, 7'd37, 7'd32, 7'd27, 7'd23, 7'd21, 7'd18},
    '{7'd64, 7'd55, 7'd48, 7'd41, 7'd36, 7'd32, 7'd28, 7'd25, 7'd22},
    '{7'd64, 7'd57, 7'd50, 7'd45, 7'd40, 7'd35, 7'd32, 7'd28, 7'd26},
    '{7'd64, 7'd58, 7'd52, 7'd47, 7'd42, 7'd38, 7'd35, 7'd32, 7'd29},
    '{7'd64, 7'd58, 7'd54, 7'd49, 7'd45, 7'd41, 7'd37, 7'd34, 7'd32}
  };

  function automatic logic [DirW-1:0] atan_code(logic [3:0] xn, logic [3:0] yn);
    logic [3:0] ax;
    logic [3:0] ay;
    logic [7:0] f;
    logic [7:0] cf;
    logic       exact;
    ax = xn[3] ? 4'(-xn) : xn;
    ay = yn[3] ? 4'(-yn) : yn;
    f = {1'b0, QUAD_FLOOR[ax][ay]};
    exact = (ax == 4'd0) || (ay == 4'd0) || (ax == ay);
    cf = exact ? f : f + 8'd1;
    if (!xn[3] && !yn[3]) return f;
    if (!xn[3]) return 8'd128 - cf;
    if (!yn[3]) return 8'd0 - cf;
    return 8'd128 + f;
  endfunction

endpackage

FILE: sv/gradient_polar_nonmax_suppress.sv
// Top level: register port, front end, column queue and suppression back end.
//
//  channel  direction  handshake              payload
//  pix      in         pix_valid / pix_stall  gx_code, gy_code, frame_start
//  res      out        res_valid / res_stall  edge_strength, row_end
//  apb      in         psel / penable         paddr, pwdata, prdata
//
// One pixel per cycle unless a side stalls; results pass the front, queue and back-end registers.
// The line-store read and write share one column slot, forwarded between neighbors.
// Reset clears counters, window and queue; line stores hold no reset contents.
// Either side may stall: the queue and output register absorb it without losing a transaction.
module gradient_polar_nonmax_suppress import gpnms_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  logic [7:0]       gx_code,
  input  logic [7:0]       gy_code,
  input  logic             frame_start,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [MagW-1:0]  edge_strength,
  output logic             row_end
);

  logic [11:0] padded_width;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  gpnms_col_t  q_in;
  gpnms_col_t  q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_PADDED_WIDTH) ? {20'd0, padded_width} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width <= PADDED_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_PADDED_WIDTH) begin
      padded_width <= pwdata[11:0];
    end
  end

  gpnms_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .padded_width (padded_width),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .gx_code      (gx_code),
    .gy_code      (gy_code),
    .frame_start  (frame_start),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  gpnms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  gpnms_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .edge_strength (edge_strength),
    .row_end       (row_end)
  );

endmodule

FILE: sv/gpnms_front.sv
// Front end: pixel intake, magnitude and direction, row and column tracking, line stores.
module gpnms_front import gpnms_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [11:0]      padded_width,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  logic [7:0]       gx_code,
  input  logic [7:0]       gy_code,
  input  logic             frame_start,
  output logic             q_push,
  output gpnms_col_t       q_data,
  input  logic             q_full
);

  localparam int Cw = $clog2(MAX_WIDTH);
  localparam int Ew = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

  logic [PixW-1:0] mem_upper [MAX_WIDTH];
  logic [PixW-1:0] mem_lower [MAX_WIDTH];

  logic [Cw-1:0]   column_count;
  logic [1:0]      row_count;

  logic            s1_valid;
  logic [Cw-1:0]   s1_col;
  logic [14:0]     s1_sq_x;
  logic [14:0]     s1_sq_y;
  logic [DirW-1:0] s1_dir;
  logic            s1_emit;
  logic            s1_last;
  logic [PixW-1:0] rd_upper;
  logic [PixW-1:0] rd_lower;

  logic            accept;
  logic            s1_adv;
  logic [Cw-1:0]   col;
  logic [1:0]      rows;
  logic [Ew-1:0]   width_ext;
  logic [Ew-1:0]   width_eff;
  logic            last;
  logic            bypass;
  logic [7:0]      gx_bin;
  logic [7:0]      gy_bin;
  logic signed [15:0] gx_sq;
  logic signed [15:0] gy_sq;
  logic [16:0]     mag_sum;
  logic [PixW-1:0] s1_pix;

  assign s1_adv    = s1_valid && !q_full;
  assign pix_stall = s1_valid && q_full;
  assign accept    = pix_valid && !pix_stall;

  always_comb begin
    width_ext = Ew'(padded_width);
    if (width_ext < Ew'(3)) begin
      width_eff = Ew'(3);
    end else if (width_ext > Ew'(MAX_WIDTH)) begin
      width_eff = Ew'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
  end

  assign col    = frame_start ? '0 : column_count;
  assign rows   = frame_start ? 2'd0 : row_count;
  assign last   = (Ew'(col) + Ew'(1)) >= width_eff;
  assign bypass = s1_adv && (s1_col == col);

  assign gx_bin = gx_code ^ 8'h80;
  assign gy_bin = gy_code ^ 8'h80;
  assign gx_sq  = $signed(gx_bin) * $signed(gx_bin);
  assign gy_sq  = $signed(gy_bin) * $signed(gy_bin);

  assign mag_sum = 17'(s1_sq_x) + 17'(s1_sq_y) + 17'd256;
  assign s1_pix  = {mag_sum[15:9], s1_dir};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= 2'd0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
      if (accept) begin
        s1_col   <= col;
        s1_sq_x  <= gx_sq[14:0];
        s1_sq_y  <= gy_sq[14:0];
        s1_dir   <= atan_code(gx_bin[7:4], gy_bin[7:4]);
        s1_emit  <= (rows == 2'd2) && (col >= Cw'(2));
        s1_last  <= last;
        if (last) begin
          column_count <= '0;
          row_count    <= (rows == 2'd2) ? rows : rows + 2'd1;
        end else begin
          column_count <= col + Cw'(1);
          row_count    <= rows;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_upper <= bypass ? rd_lower : mem_upper[col];
      rd_lower <= bypass ? s1_pix : mem_lower[col];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem_upper[s1_col] <= rd_lower;
      mem_lower[s1_col] <= s1_pix;
    end
  end

  assign q_push       = s1_adv;
  assign q_data.upper = rd_upper;
  assign q_data.lower = rd_lower;
  assign q_data.fresh = s1_pix;
  assign q_data.emit  = s1_emit;
  assign q_data.last  = s1_last;

endmodule

FILE: sv/gpnms_queue.sv
// Short column queue between the front end and the suppression back end.
module gpnms_queue import gpnms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  gpnms_col_t push_data,
  output logic       full,
  input  logic       pop,
  output gpnms_col_t head,
  output logic       empty
);

  gpnms_col_t           slots [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr;
  logic [QueueAw-1:0]   rd_ptr;
  logic [QueueAw:0]     count;

  assign full  = count == (QueueAw+1)'(QueueDepth);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QueueAw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QueueAw'(1);
      end
      if (push && !pop) begin
        count <= count + (QueueAw+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QueueAw+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_push_fills: assert property (@(posedge clk) disable iff (rst) push && !pop |=> !empty)
    else $error("queue empty after lone push");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QueueAw+1)'(QueueDepth))
    else $error("queue count out of range");
`endif

endmodule

FILE: sv/gpnms_back.sv
// Back end: 3x3 window, directional interpolation and suppression, result register.
module gpnms_back import gpnms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  gpnms_col_t       head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [MagW-1:0]  edge_strength,
  output logic             row_end
);

  logic [PixW-1:0] window [6];

  logic            b1_valid;
  logic [MagW-1:0] b1_a;
  logic [MagW-1:0] b1_b;
  logic [MagW-1:0] b1_c;
  logic [MagW-1:0] b1_d;
  logic [MagW-1:0] b1_centre;
  logic [4:0]      b1_res;
  logic            b1_last;

  logic            b1_go;
  logic [MagW-1:0] nb [8];
  logic [DirW-1:0] theta;
  logic [2:0]      lo;
  logic [2:0]      hi;
  logic [MagW-1:0] low;
  logic [MagW-1:0] high;

  function automatic logic [MagW-1:0] blend(logic [MagW-1:0] a, logic [MagW-1:0] b,
                                            logic [4:0] res);
    logic [11:0] acc;
    acc = 12'(a) * (12'd32 - 12'(res)) + 12'(b) * 12'(res);
    return acc[11:5];
  endfunction

  assign b1_go = !res_valid || !res_stall;
  assign q_pop = !q_empty && (!b1_valid || b1_go);

  assign nb[0] = window[3][14:8];
  assign nb[1] = window[0][14:8];
  assign nb[2] = window[1][14:8];
  assign nb[3] = window[2][14:8];
  assign nb[4] = window[5][14:8];
  assign nb[5] = head.fresh[14:8];
  assign nb[6] = head.lower[14:8];
  assign nb[7] = head.upper[14:8];

  assign theta = window[4][7:0];
  assign lo    = theta[7:5];
  assign hi    = lo + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        window[i] <= '0;
      end
    end else begin
      b1_valid <= q_pop ? head.emit : (b1_valid && !b1_go);
      if (q_pop) begin
        b1_a      <= nb[lo];
        b1_b      <= nb[hi];
        b1_c      <= nb[lo ^ 3'b100];
        b1_d      <= nb[hi ^ 3'b100];
        b1_centre <= window[4][14:8];
        b1_res    <= theta[4:0];
        b1_last   <= head.last;
        window[0] <= window[3];
        window[1] <= window[4];
        window[2] <= window[5];
        window[3] <= head.upper;
        window[4] <= head.lower;
        window[5] <= head.fresh;
      end
    end
  end

  assign low  = blend(b1_a, b1_b, b1_res);
  assign high = blend(b1_c, b1_d, b1_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b1_go) begin
      res_valid     <= b1_valid;
      edge_strength <= (b1_centre <= low || b1_centre < high) ? '0 : b1_centre;
      row_end       <= b1_last;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for gradient_polar_nonmax_suppress with a predicting scoreboard.
module tb_top;
  import gpnms_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 680;
  localparam int WIDE_ITEMS    = 40;
  localparam int MAX_COLS      = 2048;
  localparam logic [2:0] WIDTH_ADDR = 3'(4 * REG_PADDED_WIDTH);

  localparam int ANGLE_FLOOR [9][9] = '{
    '{ 0,  0,  0,  0,  0,  0,  0,  0,  0},
    '{64, 32, 18, 13,  9,  8,  6,  5,  5},
    '{64, 45, 32, 23, 18, 15, 13, 11,  9},
    '{64, 50, 40, 32, 26, 22, 18, 16, 14},
    '{64, 54, 45, 37, 32, 27, 23, 21, 18},
    '{64, 55, 48, 41, 36, 32, 28, 25, 22},
    '{64, 57, 50, 45, 40, 35, 32, 28, 26},
    '{64, 58, 52, 47, 42, 38, 35, 32, 29},
    '{64, 58, 54, 49, 45, 41, 37, 34, 32}
  };
  localparam int NB_ROW [8] = '{0, 0, 1, 2, 2, 2, 1, 0};
  localparam int NB_COL [8] = '{1, 0, 0, 0, 1, 2, 2, 2};

  localparam logic [7:0] EDGE_CODES [16] = '{
    8'h00, 8'hff, 8'h80, 8'h7f, 8'h81, 8'h01, 8'hfe, 8'h0f,
    8'hf0, 8'h55, 8'haa, 8'h40, 8'hc0, 8'h88, 8'h77, 8'h08
  };

  typedef enum int {PAT_UNIFORM, PAT_QUIET, PAT_EXTREME, PAT_RIDGE} pattern_t;

  typedef struct packed {
    logic [MagW-1:0] strength;
    logic            last;
  } thin_t;

  class nms_scoreboard;
    logic [11:0]     width_cfg;
    logic [PixW-1:0] upper_row [MAX_COLS];
    logic [PixW-1:0] lower_row [MAX_COLS];
    logic [PixW-1:0] win [6];
    int              col_cnt;
    int              row_cnt;
    thin_t           pending [$];
    int              errors;
    int              checked;

    function new();
      width_cfg = PADDED_WIDTH_RESET;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function logic [7:0] angle_code(int x, int y);
      int ax;
      int ay;
      int f;
      int cf;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      f = ANGLE_FLOOR[ax][ay];
      cf = (ax == 0 || ay == 0 || ax == ay) ? f : f + 1;
      if (x >= 0 && y >= 0) return 8'(f);
      if (x >= 0) return 8'(128 - cf);
      if (y >= 0) return 8'(256 - cf);
      return 8'(128 + f);
    endfunction

    function int blend(int a, int b, int r);
      return (a * (32 - r) + b * r) / 32;
    endfunction

    function void note_pixel(logic [7:0] gxc, logic [7:0] gyc, logic fs);
      int gx;
      int gy;
      int w;
      int c;
      int lo;
      int hi;
      int r;
      int lowv;
      int highv;
      int center;
      int g [3][3];
      logic [MagW-1:0] mag;
      logic [7:0]      dir;
      logic [PixW-1:0] pix;
      logic [PixW-1:0] up;
      logic [PixW-1:0] dn;
      logic            last;
      gx = int'(gxc) - 128;
      gy = int'(gyc) - 128;
      mag = MagW'((gx * gx + gy * gy + 256) >> 9);
      dir = angle_code(gx >>> 4, gy >>> 4);
      pix = {mag, dir};
      w = int'(width_cfg);
      if (w < 3) w = 3;
      if (w > MAX_COLS) w = MAX_COLS;
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      c = (col_cnt > MAX_COLS - 1) ? MAX_COLS - 1 : col_cnt;
      last = (c + 1 >= w);
      up = upper_row[c];
      dn = lower_row[c];
      if (row_cnt >= 2 && c >= 2) begin
        for (r = 0; r < 3; r++) begin
          g[r][0] = int'(win[r][PixW-1:8]);
          g[r][1] = int'(win[3 + r][PixW-1:8]);
        end
        g[0][2] = int'(up[PixW-1:8]);
        g[1][2] = int'(dn[PixW-1:8]);
        g[2][2] = int'(mag);
        center = g[1][1];
        lo = int'(win[4][7:5]);
        hi = (lo + 1) % 8;
        r = int'(win[4][4:0]);
        lowv = blend(g[NB_ROW[lo]][NB_COL[lo]], g[NB_ROW[hi]][NB_COL[hi]], r);
        highv = blend(g[NB_ROW[(lo + 4) % 8]][NB_COL[(lo + 4) % 8]],
                      g[NB_ROW[(hi + 4) % 8]][NB_COL[(hi + 4) % 8]], r);
        if (center <= lowv || center < highv) center = 0;
        pending.push_back(thin_t'{MagW'(center), last});
      end
      upper_row[c] = dn;
      lower_row[c] = pix;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = up;
      win[4] = dn;
      win[5] = pix;
      if (last) begin
        col_cnt = 0;
        if (row_cnt < 2) row_cnt++;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_result(logic [MagW-1:0] strength, logic last);
      thin_t want;
      checked++;
      if (pending.size() == 0) begin
        flag($sformatf("result %0d: unexpected, strength %0d row_end %0b",
                       checked, strength, last));
        return;
      end
      want = pending.pop_front();
      if (want.strength !== strength || want.last !== last)
        flag($sformatf("result %0d: expected strength %0d row_end %0b, got %0d %0b",
                       checked, want.strength, want.last, strength, last));
    endfunction

    function void check_width(logic [31:0] rd);
      if (rd[11:0] !== width_cfg)
        flag($sformatf("padded_width read: expected %0d, got %0d", width_cfg, rd[11:0]));
    endfunction

    function void close_out();
      if (pending.size() != 0)
        flag($sformatf("%0d expected results never arrived", pending.size()));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             pix_valid = 1'b0;
  logic             pix_stall;
  logic [7:0]       gx_code = '0;
  logic [7:0]       gy_code = '0;
  logic             frame_start = 1'b0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  logic [MagW-1:0]  edge_strength;
  logic             row_end;

  nms_scoreboard sb;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  gradient_polar_nonmax_suppress dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .gx_code(gx_code),
    .gy_code(gy_code),
    .frame_start(frame_start),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .edge_strength(edge_strength),
    .row_end(row_end)
  );

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0)
      sb.check_result(edge_strength, row_end);
  end

  always @(posedge clk) begin
    if ((pix_valid && pix_stall === 1'b0) || (res_valid === 1'b1 && !res_stall) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : receiver
    int held;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_stall <= 1'b1;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
      end else begin
        res_stall <= !calm && ($urandom_range(99) < 20);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] gx, input logic [7:0] gy, input logic fs);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 20) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    gx_code <= gx;
    gy_code <= gy;
    frame_start <= fs;
    @(posedge clk);
    while (pix_stall !== 1'b0) @(posedge clk);
    sb.note_pixel(gx, gy, fs);
  endtask

  task automatic drain();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_width_check();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= WIDTH_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.check_width(prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_width(input logic [11:0] v);
    drain();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WIDTH_ADDR;
    pwdata <= {20'($urandom), v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.width_cfg = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_width_check();
  endtask

  function automatic void pick_pair(input pattern_t mode, input int col, input int ridge,
                                    output logic [7:0] gx, output logic [7:0] gy);
    int d;
    case (mode)
      PAT_UNIFORM: begin
        gx = 8'($urandom_range(255));
        gy = 8'($urandom_range(255));
      end
      PAT_QUIET: begin
        gx = 8'($urandom_range(152, 104));
        gy = 8'($urandom_range(152, 104));
      end
      PAT_EXTREME: begin
        gx = EDGE_CODES[$urandom_range(15)];
        gy = EDGE_CODES[$urandom_range(15)];
      end
      default: begin
        d = (col > ridge) ? col - ridge : ridge - col;
        gx = (d == 0) ? 8'd228 : (d == 1) ? 8'd188 : 8'($urandom_range(133, 123));
        gy = 8'($urandom_range(136, 120));
      end
    endcase
  endfunction

  task automatic stream_pixels(input int w, input int count, input pattern_t mode,
                               input bit new_frame, input bit noisy, input int hold_at);
    int i;
    int ridge;
    logic [7:0] gx;
    logic [7:0] gy;
    logic fs;
    ridge = $urandom_range(w - 1);
    for (i = 0; i < count; i++) begin
      fs = (new_frame && i == 0) || (noisy && $urandom_range(99) < 2);
      pick_pair(mode, i % w, ridge, gx, gy);
      send_pixel(gx, gy, fs);
      if (i == hold_at) hold_request = 1'b1;
    end
  endtask

  initial begin : stimulus
    int i;
    int rand_items;
    int pick;
    int wcfg;
    int weff;
    int rows;
    int n;
    int stop;
    int nw;
    bit partial;
    pattern_t mode;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    read_width_check();

    // three rows of four, then part of a fourth row
    set_width(12'd4);
    for (i = 0; i < 15; i++)
      send_pixel(EDGE_CODES[i % 16], EDGE_CODES[(i * 7 + 3) % 16], i == 0);
    // shrink below the current column: the row ends on the next transaction
    set_width(12'd2);
    for (i = 15; i < 19; i++)
      send_pixel(EDGE_CODES[i % 16], EDGE_CODES[(i * 5 + 1) % 16], 1'b0);
    for (i = 19; i < 22; i++)
      send_pixel(EDGE_CODES[i % 16], EDGE_CODES[(i * 3 + 2) % 16], i == 19);

    set_width(12'hfff);
    stream_pixels(MAX_COLS, WIDE_ITEMS, PAT_UNIFORM, 1'b1, 1'b0, -1);

    set_width(12'd5);
    stream_pixels(5, 60, PAT_RIDGE, 1'b1, 1'b0, 22);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      calm = (rand_items >= 300 && rand_items < 450);
      pick = $urandom_range(99);
      if (pick < 10) wcfg = $urandom_range(2);
      else if (pick < 20) wcfg = $urandom_range(40, 13);
      else wcfg = $urandom_range(12, 3);
      weff = (wcfg < 3) ? 3 : wcfg;
      rows = $urandom_range(6, 3);
      mode = pattern_t'($urandom_range(3));
      n = rows * weff;
      partial = ($urandom_range(9) == 0);
      if (partial) n += $urandom_range(weff - 1, 1);
      set_width(12'(wcfg));
      stream_pixels(weff, n, mode, 1'b1, $urandom_range(3) == 0, -1);
      rand_items += n;
      if (!partial && weff >= 5 && $urandom_range(4) == 0) begin
        stop = $urandom_range(weff - 1, 2);
        stream_pixels(weff, stop, mode, 1'b0, 1'b0, -1);
        nw = $urandom_range(stop + 1, 3);
        set_width(12'(nw));
        stream_pixels(nw, 1 + 2 * nw, mode, 1'b0, 1'b0, -1);
        rand_items += stop + 1 + 2 * nw;
      end
    end

    calm = 1'b0;
    drain();
    sb.close_out();
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
